/* src/imudr_pkg.sv */
// package: shared types, constants and arithmetic helpers for the dead reckoning block
`timescale 1ns / 1ps

package imudr_pkg;

	typedef struct packed {
		logic signed [31:0] raw_accel_x;
		logic signed [31:0] raw_accel_y;
		logic signed [31:0] raw_accel_z;
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic [15:0]        elapsed_ticks;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] world_accel_x;
		logic signed [31:0] world_accel_y;
		logic signed [31:0] world_accel_z;
		logic signed [47:0] velocity_x;
		logic signed [47:0] velocity_y;
		logic signed [47:0] velocity_z;
		logic signed [47:0] position_x;
		logic signed [47:0] position_y;
		logic signed [47:0] position_z;
	} out_item_t;

	// controller to datapath command
	typedef struct packed {
		logic       load;
		logic       seed;
		logic       run;
		logic       acc;
		logic       publish;
		logic [5:0] step;
	} cmd_t;

	// register indexes
	localparam logic [1:0] REG_OFFSET_X    = 2'd0;
	localparam logic [1:0] REG_OFFSET_Y    = 2'd1;
	localparam logic [1:0] REG_OFFSET_Z    = 2'd2;
	localparam logic [1:0] REG_TICK_PERIOD = 2'd3;

	// filter coefficients, Q2.30
	localparam logic signed [32:0] COEF_A = 33'sd2071735500;
	localparam logic signed [32:0] COEF_B = -33'sd1000494913;
	localparam logic signed [32:0] COEF_C = 33'sd2501237;

	localparam logic signed [66:0] GRAVITY_Q16 = 67'sd642689;
	localparam logic [31:0] TICK_PERIOD_RESET = 32'd4294967;
	localparam logic [31:0] DT_LONG_FALLBACK  = 32'd4294967;
	localparam logic [31:0] DT_ZERO_FALLBACK  = 32'd4295;
	localparam logic [47:0] DT_MAX            = 48'd429496729;

	// micro-step map of the sequencer
	localparam logic [5:0] ST_FILT  = 6'd0;
	localparam logic [5:0] ST_PROD  = 6'd9;
	localparam logic [5:0] ST_ROT   = 6'd19;
	localparam logic [5:0] ST_WORLD = 6'd20;
	localparam logic [5:0] ST_DT    = 6'd29;
	localparam logic [5:0] ST_VEL   = 6'd30;
	localparam logic [5:0] ST_POS   = 6'd33;
	localparam logic [5:0] ST_LAST  = 6'd38;

	// round half away from zero of v / 2^sh
	function automatic logic signed [66:0] rdiv(input logic signed [66:0] v, input int sh);
		logic [66:0] m;
		m = v[66] ? 67'(-v) : 67'(v);
		m = (m + (67'd1 << (sh - 1))) >> sh;
		return v[66] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		if (v > 67'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -67'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [66:0] v);
		if (v > 67'sd140737488355327)
			return 48'sh7fffffffffff;
		else if (v < -67'sd140737488355328)
			return 48'sh800000000000;
		else
			return v[47:0];
	endfunction

	// value below nine split into {v / 3, v % 3}
	function automatic logic [3:0] split3(input logic [3:0] v);
		if (v >= 4'd6)
			return {2'd2, 2'(v - 4'd6)};
		else if (v >= 4'd3)
			return {2'd1, 2'(v - 4'd3)};
		else
			return {2'd0, v[1:0]};
	endfunction

	// quaternion product index to {i, j}
	function automatic logic [3:0] pair(input logic [3:0] k);
		unique case (k)
			4'd0: return {2'd0, 2'd0};
			4'd1: return {2'd1, 2'd1};
			4'd2: return {2'd2, 2'd2};
			4'd3: return {2'd3, 2'd3};
			4'd4: return {2'd0, 2'd1};
			4'd5: return {2'd0, 2'd2};
			4'd6: return {2'd0, 2'd3};
			4'd7: return {2'd1, 2'd2};
			4'd8: return {2'd1, 2'd3};
			4'd9: return {2'd2, 2'd3};
			default: return 4'd0;
		endcase
	endfunction

endpackage

/* src/imudr_ctrl.sv */
// controller: sequences load, filter seeding, micro-steps and result hand-off
`timescale 1ns / 1ps

module imudr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output imudr_pkg::cmd_t   cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEED   = 2'd1;
	localparam logic [1:0] S_RUN    = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [5:0] step_q;
	logic       phase_q;
	logic       out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.step    = step_q;
		cmd.acc     = phase_q;
		cmd.run     = (state_q == S_RUN);
		cmd.load    = (state_q == S_IDLE) && in_valid;
		cmd.seed    = (state_q == S_SEED);
		cmd.publish = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SEED;
				end
				S_SEED: begin
					state_q <= S_RUN;
					step_q  <= imudr_pkg::ST_FILT;
					phase_q <= 1'b0;
				end
				S_RUN: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (step_q == imudr_pkg::ST_LAST)
							state_q <= S_FINISH;
						else
							step_q <= step_q + 6'd1;
					end
				end
				S_FINISH: begin
					if (cmd.publish)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* src/imudr_dp.sv */
// datapath: registers, filter taps, integrators and one shared 33x33 multiplier
`timescale 1ns / 1ps

module imudr_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imudr_pkg::cmd_t       cmd,
	input  imudr_pkg::in_item_t   in_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	output imudr_pkg::out_item_t  out_data
);

	// configuration
	logic signed [31:0] offx_q, offy_q, offz_q;
	logic [31:0]        tp_q;

	// architectural state
	logic signed [31:0] fl_q [3];
	logic signed [31:0] fb_q [3];
	logic signed [47:0] vel_q [3];
	logic signed [47:0] pos_q [3];
	logic               seeded_q;

	// working registers
	logic signed [31:0] q_q [4];
	logic [15:0]        ticks_q;
	logic signed [31:0] body_q [3];
	logic signed [31:0] filt_q [3];
	logic signed [34:0] p_q [10];
	logic signed [31:0] r_q [9];
	logic signed [31:0] w_q [3];
	logic [31:0]        dt_q;
	logic [52:0]        hi_q;
	logic signed [65:0] prod_q;
	logic signed [66:0] acc_q;
	imudr_pkg::out_item_t out_q;

	// decode
	logic [5:0] w_off, k_off, v_off, p_off;
	logic [3:0] fs, ws, pr;
	logic [1:0] v_ax, p_ax;
	logic [47:0] mag;
	logic signed [32:0] op_a, op_b;

	// combinational results
	logic signed [31:0] body_n [3];
	logic signed [66:0] prod_ext, acc_sum, term30, term24;
	logic signed [31:0] filt_y;
	logic signed [66:0] e [10];
	logic signed [31:0] r_n [9];
	logic [55:0]        low_sum, pos_step;
	logic signed [66:0] pos_sum;
	logic signed [66:0] world_sum;

	assign w_off = cmd.step - imudr_pkg::ST_WORLD;
	assign k_off = cmd.step - imudr_pkg::ST_PROD;
	assign v_off = cmd.step - imudr_pkg::ST_VEL;
	assign p_off = cmd.step - imudr_pkg::ST_POS;
	assign fs    = imudr_pkg::split3(cmd.step[3:0]);
	assign ws    = imudr_pkg::split3(w_off[3:0]);
	assign pr    = imudr_pkg::pair(k_off[3:0]);
	assign v_ax  = v_off[1:0];
	assign p_ax  = p_off[2:1];
	assign mag   = vel_q[p_ax][47] ? 48'(-vel_q[p_ax]) : 48'(vel_q[p_ax]);

	// mount rotation x'=y, y'=-x, z'=z plus offsets
	assign body_n[0] = imudr_pkg::sat32(67'(in_data.raw_accel_y) + 67'(offx_q));
	assign body_n[1] = imudr_pkg::sat32(-67'(in_data.raw_accel_x) + 67'(offy_q));
	assign body_n[2] = imudr_pkg::sat32(67'(in_data.raw_accel_z) + 67'(offz_q));

	// operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (cmd.step < imudr_pkg::ST_PROD) begin
			unique case (fs[1:0])
				2'd0: begin
					op_a = imudr_pkg::COEF_A;
					op_b = 33'(fl_q[fs[3:2]]);
				end
				2'd1: begin
					op_a = imudr_pkg::COEF_B;
					op_b = 33'(fb_q[fs[3:2]]);
				end
				default: begin
					op_a = imudr_pkg::COEF_C;
					op_b = 33'(body_q[fs[3:2]]);
				end
			endcase
		end else if (cmd.step < imudr_pkg::ST_ROT) begin
			op_a = 33'(q_q[pr[3:2]]);
			op_b = 33'(q_q[pr[1:0]]);
		end else if (cmd.step == imudr_pkg::ST_ROT) begin
			op_a = '0;
			op_b = '0;
		end else if (cmd.step < imudr_pkg::ST_DT) begin
			op_a = 33'(r_q[w_off[3:0]]);
			op_b = 33'(filt_q[ws[1:0]]);
		end else if (cmd.step == imudr_pkg::ST_DT) begin
			op_a = {17'd0, ticks_q};
			op_b = {1'b0, tp_q};
		end else if (cmd.step < imudr_pkg::ST_POS) begin
			op_a = 33'(w_q[v_ax]);
			op_b = {1'b0, dt_q};
		end else begin
			op_a = p_off[0] ? {9'd0, mag[23:0]} : {9'd0, mag[47:24]};
			op_b = {1'b0, dt_q};
		end
	end

	// post-multiply arithmetic
	always_comb begin
		prod_ext = 67'(prod_q);
		acc_sum  = acc_q + prod_ext;
		filt_y   = imudr_pkg::sat32(imudr_pkg::rdiv(acc_sum, 30));
		term30   = imudr_pkg::rdiv(prod_ext, 30);
		term24   = imudr_pkg::rdiv(prod_ext, 24);
		world_sum = acc_q + term30 - ((ws[3:2] == 2'd2) ? imudr_pkg::GRAVITY_Q16 : 67'sd0);
		for (int k = 0; k < 10; k++)
			e[k] = 67'(p_q[k]);
		// p order: 00 11 22 33 01 02 03 12 13 23
		r_n[0] = imudr_pkg::sat32(e[0] + e[1] - e[2] - e[3]);
		r_n[1] = imudr_pkg::sat32((e[7] - e[6]) <<< 1);
		r_n[2] = imudr_pkg::sat32((e[8] + e[5]) <<< 1);
		r_n[3] = imudr_pkg::sat32((e[7] + e[6]) <<< 1);
		r_n[4] = imudr_pkg::sat32(e[0] - e[1] + e[2] - e[3]);
		r_n[5] = imudr_pkg::sat32((e[9] - e[4]) <<< 1);
		r_n[6] = imudr_pkg::sat32((e[8] - e[5]) <<< 1);
		r_n[7] = imudr_pkg::sat32((e[9] + e[4]) <<< 1);
		r_n[8] = imudr_pkg::sat32(e[0] - e[1] - e[2] + e[3]);
		// position step: (mag * dt + 2^31) >> 32 from the two partial products
		low_sum  = (56'(hi_q[7:0]) << 24) + 56'(prod_q[52:0]) + 56'h0000_0080_0000_00;
		pos_step = 56'(hi_q[52:8]) + 56'(low_sum[55:32]);
		pos_sum  = vel_q[p_ax][47] ? (67'(pos_q[p_ax]) - $signed({11'd0, pos_step}))
		                           : (67'(pos_q[p_ax]) + $signed({11'd0, pos_step}));
	end

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offx_q   <= '0;
			offy_q   <= '0;
			offz_q   <= '0;
			tp_q     <= imudr_pkg::TICK_PERIOD_RESET;
			seeded_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				fl_q[i]  <= '0;
				fb_q[i]  <= '0;
				vel_q[i] <= '0;
				pos_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					imudr_pkg::REG_OFFSET_X:    offx_q <= cfg_data;
					imudr_pkg::REG_OFFSET_Y:    offy_q <= cfg_data;
					imudr_pkg::REG_OFFSET_Z:    offz_q <= cfg_data;
					imudr_pkg::REG_TICK_PERIOD: tp_q   <= cfg_data;
					default: ;
				endcase
			end
			// first sample after reset passes straight through the filter
			if (cmd.seed && !seeded_q) begin
				seeded_q <= 1'b1;
				for (int i = 0; i < 3; i++) begin
					fl_q[i] <= body_q[i];
					fb_q[i] <= body_q[i];
				end
			end
			if (cmd.run && cmd.acc) begin
				if (cmd.step < imudr_pkg::ST_PROD) begin
					if (fs[1:0] == 2'd2) begin
						fb_q[fs[3:2]] <= fl_q[fs[3:2]];
						fl_q[fs[3:2]] <= filt_y;
					end
				end else if (cmd.step >= imudr_pkg::ST_VEL && cmd.step < imudr_pkg::ST_POS) begin
					vel_q[v_ax] <= imudr_pkg::sat48(67'(vel_q[v_ax]) + term24);
				end else if (cmd.step >= imudr_pkg::ST_POS && p_off[0]) begin
					pos_q[p_ax] <= imudr_pkg::sat48(pos_sum);
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (cmd.load) begin
			q_q[0]  <= in_data.quat_w;
			q_q[1]  <= in_data.quat_x;
			q_q[2]  <= in_data.quat_y;
			q_q[3]  <= in_data.quat_z;
			ticks_q <= in_data.elapsed_ticks;
			for (int i = 0; i < 3; i++)
				body_q[i] <= body_n[i];
		end
		if (cmd.run && cmd.acc) begin
			if (cmd.step < imudr_pkg::ST_PROD) begin
				unique case (fs[1:0])
					2'd0:    acc_q <= prod_ext;
					2'd1:    acc_q <= acc_sum;
					default: filt_q[fs[3:2]] <= filt_y;
				endcase
			end else if (cmd.step < imudr_pkg::ST_ROT) begin
				p_q[k_off[3:0]] <= term30[34:0];
			end else if (cmd.step == imudr_pkg::ST_ROT) begin
				for (int k = 0; k < 9; k++)
					r_q[k] <= r_n[k];
			end else if (cmd.step < imudr_pkg::ST_DT) begin
				unique case (ws[1:0])
					2'd0:    acc_q <= term30;
					2'd1:    acc_q <= acc_q + term30;
					default: w_q[ws[3:2]] <= imudr_pkg::sat32(world_sum);
				endcase
			end else if (cmd.step == imudr_pkg::ST_DT) begin
				if (prod_q[47:0] == 48'd0)
					dt_q <= imudr_pkg::DT_ZERO_FALLBACK;
				else if (prod_q[47:0] > imudr_pkg::DT_MAX)
					dt_q <= imudr_pkg::DT_LONG_FALLBACK;
				else
					dt_q <= prod_q[31:0];
			end else if (cmd.step >= imudr_pkg::ST_POS && !p_off[0]) begin
				hi_q <= prod_q[52:0];
			end
		end
		if (cmd.publish) begin
			out_q.world_accel_x <= w_q[0];
			out_q.world_accel_y <= w_q[1];
			out_q.world_accel_z <= w_q[2];
			out_q.velocity_x    <= vel_q[0];
			out_q.velocity_y    <= vel_q[1];
			out_q.velocity_z    <= vel_q[2];
			out_q.position_x    <= pos_q[0];
			out_q.position_y    <= pos_q[1];
			out_q.position_z    <= pos_q[2];
		end
	end

	assign out_data = out_q;

endmodule

/* src/imu_linear_accel_dead_reckoning.sv */
// top level: gravity-compensated dead reckoning from one IMU sample per transfer
`timescale 1ns / 1ps

// Each input transfer carries a raw body acceleration (Q16.16), a body-to-world
// attitude quaternion (Q2.30) and the tick count since the previous sample. The
// sample is turned by the board mount (x'=y, y'=-x, z'=z), offset corrected,
// low-pass filtered per axis (the first sample after reset seeds the filter),
// rotated to the world frame with gravity removed from z, and integrated into
// velocity (2^-24 m/s) and position (2^-24 m). One result transfer leaves per
// input transfer. An item goes through load, seed, 39 micro-steps on the single
// shared 33x33 multiplier and hand-off, and no new input transfer is taken
// before that hand-off. The finished result sits in an output register, so the
// next input transfer is taken while a result still waits for the consumer.
// Configuration writes (offsets, tick period) are taken in any cycle and belong
// in idle time.
module imu_linear_accel_dead_reckoning (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  imudr_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output imudr_pkg::out_item_t  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	imudr_pkg::cmd_t cmd;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// sequencer
	imudr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// arithmetic, state and output register
	imudr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

endmodule

/* src/imudr_chk.sv */
// checker: port-level properties of the dead reckoning block, bound to the top level
`timescale 1ns / 1ps

module imudr_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input imudr_pkg::out_item_t  out_data,
	input logic                  cfg_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item at a time: busy right after an input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result appears only as the block goes idle
	a_publish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result published while still computing");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("register write stalled");

endmodule

bind imu_linear_accel_dead_reckoning imudr_chk u_chk (.*);

/* bench/dead_reckoning_checker.sv */
// checker: predicts the dead reckoning results from observed transfers and compares them
`timescale 1ns / 1ps

module dead_reckoning_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  imudr_pkg::in_item_t   in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  imudr_pkg::out_item_t  out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	output int                    fail_count,
	output int                    pending_count
);

	localparam longint LIM32_HI = 64'sd2147483647;
	localparam longint LIM32_LO = -64'sd2147483648;
	localparam longint LIM48_HI = 64'sd140737488355327;
	localparam longint LIM48_LO = -64'sd140737488355328;

	logic signed [31:0] offset_x, offset_y, offset_z;
	logic [31:0]        period;
	longint             tap_last [3];
	longint             tap_prev [3];
	longint             vel [3];
	longint             pos [3];
	bit                 primed;
	imudr_pkg::out_item_t expected_results [$];

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// round half away from zero of v / 2^s
	function automatic longint round_shift(longint v, int s);
		longint unsigned m;
		m = v < 0 ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	// one sample through mount, filter, rotation, gravity and integration
	function automatic imudr_pkg::out_item_t dead_reckon(imudr_pkg::in_item_t s);
		longint body [3], filt [3], q [4], pr [4][4], rot [3][3], wa [3];
		longint acc, sum, v;
		longint unsigned raw, dt, mag, hi, lo, d;
		imudr_pkg::out_item_t r;
		body[0] = clip(longint'(s.raw_accel_y) + offset_x, LIM32_LO, LIM32_HI);
		body[1] = clip(-longint'(s.raw_accel_x) + offset_y, LIM32_LO, LIM32_HI);
		body[2] = clip(longint'(s.raw_accel_z) + offset_z, LIM32_LO, LIM32_HI);
		if (!primed) begin
			for (int i = 0; i < 3; i++) begin
				tap_last[i] = body[i];
				tap_prev[i] = body[i];
			end
			primed = 1;
		end
		for (int i = 0; i < 3; i++) begin
			acc = 64'sd2071735500 * tap_last[i] - 64'sd1000494913 * tap_prev[i]
				+ 64'sd2501237 * body[i];
			filt[i] = clip(round_shift(acc, 30), LIM32_LO, LIM32_HI);
			tap_prev[i] = tap_last[i];
			tap_last[i] = filt[i];
		end
		q[0] = s.quat_w; q[1] = s.quat_x; q[2] = s.quat_y; q[3] = s.quat_z;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				pr[i][j] = round_shift(q[i] * q[j], 30);
		rot[0][0] = pr[0][0] + pr[1][1] - pr[2][2] - pr[3][3];
		rot[0][1] = 2 * (pr[1][2] - pr[0][3]);
		rot[0][2] = 2 * (pr[1][3] + pr[0][2]);
		rot[1][0] = 2 * (pr[1][2] + pr[0][3]);
		rot[1][1] = pr[0][0] - pr[1][1] + pr[2][2] - pr[3][3];
		rot[1][2] = 2 * (pr[2][3] - pr[0][1]);
		rot[2][0] = 2 * (pr[1][3] - pr[0][2]);
		rot[2][1] = 2 * (pr[2][3] + pr[0][1]);
		rot[2][2] = pr[0][0] - pr[1][1] - pr[2][2] + pr[3][3];
		for (int i = 0; i < 3; i++) begin
			sum = 0;
			for (int j = 0; j < 3; j++)
				sum += round_shift(clip(rot[i][j], LIM32_LO, LIM32_HI) * filt[j], 30);
			if (i == 2)
				sum -= 642689;
			wa[i] = clip(sum, LIM32_LO, LIM32_HI);
		end
		raw = longint'(s.elapsed_ticks) * longint'(period);
		if (raw == 0)
			dt = 4295;
		else if (raw * 10 > (64'd1 << 32))
			dt = 4294967;
		else
			dt = raw;
		for (int i = 0; i < 3; i++) begin
			v = clip(vel[i] + round_shift(wa[i] * longint'(dt), 24), LIM48_LO, LIM48_HI);
			vel[i] = v;
			mag = v < 0 ? -v : v;
			hi = (mag >> 24) * dt;
			lo = (mag & 64'hFFFFFF) * dt + (64'd1 << 31);
			d = (hi >> 8) + ((((hi & 64'hFF) << 24) + lo) >> 32);
			pos[i] = clip(pos[i] + (v < 0 ? -longint'(d) : longint'(d)), LIM48_LO, LIM48_HI);
		end
		r.world_accel_x = wa[0][31:0];
		r.world_accel_y = wa[1][31:0];
		r.world_accel_z = wa[2][31:0];
		r.velocity_x = vel[0][47:0];
		r.velocity_y = vel[1][47:0];
		r.velocity_z = vel[2][47:0];
		r.position_x = pos[0][47:0];
		r.position_y = pos[1][47:0];
		r.position_z = pos[2][47:0];
		return r;
	endfunction

	task automatic compare_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		imudr_pkg::out_item_t e;
		if (!arst_n) begin
			offset_x = 0; offset_y = 0; offset_z = 0;
			period = imudr_pkg::TICK_PERIOD_RESET;
			for (int i = 0; i < 3; i++) begin
				tap_last[i] = 0; tap_prev[i] = 0; vel[i] = 0; pos[i] = 0;
			end
			primed = 0;
			fail_count = 0;
			expected_results.delete();
			pending_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					imudr_pkg::REG_OFFSET_X:    offset_x = cfg_data;
					imudr_pkg::REG_OFFSET_Y:    offset_y = cfg_data;
					imudr_pkg::REG_OFFSET_Z:    offset_z = cfg_data;
					imudr_pkg::REG_TICK_PERIOD: period = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no expected result");
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					compare_field("world_accel_x", e.world_accel_x, out_data.world_accel_x);
					compare_field("world_accel_y", e.world_accel_y, out_data.world_accel_y);
					compare_field("world_accel_z", e.world_accel_z, out_data.world_accel_z);
					compare_field("velocity_x", e.velocity_x, out_data.velocity_x);
					compare_field("velocity_y", e.velocity_y, out_data.velocity_y);
					compare_field("velocity_z", e.velocity_z, out_data.velocity_z);
					compare_field("position_x", e.position_x, out_data.position_x);
					compare_field("position_y", e.position_y, out_data.position_y);
					compare_field("position_z", e.position_z, out_data.position_z);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(dead_reckon(in_data));
			pending_count = expected_results.size();
		end
	end

endmodule

/* bench/testbench.sv */
// testbench top: stimulus, idling phases and verdict for the dead reckoning block
`timescale 1ns / 1ps

module testbench;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_ready;
	imudr_pkg::in_item_t  in_data = '0;
	logic       out_valid;
	logic       out_ready = 0;
	imudr_pkg::out_item_t out_data;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [1:0] cfg_index = imudr_pkg::REG_OFFSET_X;
	logic [31:0] cfg_data = 0;
	int         fail_count;
	int         pending_count;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	// 4 ns period
	always #2 clk = ~clk;

	imu_linear_accel_dead_reckoning uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	dead_reckoning_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// consumer: ready re-rolled each falling edge per the current stall rate
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// one register write transfer, only while the block is idle
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	// one sample transfer, with a random gap before it per the idle rate
	task automatic send_sample(imudr_pkg::in_item_t s);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= s;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// drop valid, let every expected result arrive, then idle a while
	task automatic drain;
		in_valid <= 0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_word;
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(1310720)) - 655360);
		endcase
	endfunction

	// quaternions: mostly near-unit, sometimes arbitrary to hit saturation
	function automatic imudr_pkg::in_item_t rand_sample;
		imudr_pkg::in_item_t s;
		real a, b, c, d, n;
		s.raw_accel_x = rand_word();
		s.raw_accel_y = rand_word();
		s.raw_accel_z = rand_word();
		if ($urandom_range(9) < 8) begin
			a = $urandom_range(2000) - 1000.0; b = $urandom_range(2000) - 1000.0;
			c = $urandom_range(2000) - 1000.0; d = $urandom_range(2000) - 1000.0;
			n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
			s.quat_w = $rtoi(a / n * 1073741824.0);
			s.quat_x = $rtoi(b / n * 1073741824.0);
			s.quat_y = $rtoi(c / n * 1073741824.0);
			s.quat_z = $rtoi(d / n * 1073741824.0);
		end else begin
			s.quat_w = $urandom; s.quat_x = $urandom;
			s.quat_y = $urandom; s.quat_z = $urandom;
		end
		case ($urandom_range(7))
			0: s.elapsed_ticks = 16'd0;
			1: s.elapsed_ticks = 16'($urandom);
			default: s.elapsed_ticks = 16'($urandom_range(20));
		endcase
		return s;
	endfunction

	initial begin
		imudr_pkg::in_item_t s;
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: first sample seeds the filter, then field extremes
		s = '0;
		s.quat_w = 32'sh40000000;
		s.raw_accel_z = 32'sd642689;
		s.elapsed_ticks = 1;
		send_sample(s);
		send_sample(s);
		s.raw_accel_x = 32'sh7fffffff; s.raw_accel_y = 32'sh80000000;
		s.raw_accel_z = 32'sh80000000;
		send_sample(s);
		s.raw_accel_x = 32'sh80000000; s.raw_accel_y = 32'sh7fffffff;
		s.raw_accel_z = 32'sh7fffffff;
		send_sample(s);
		// zero interval and long interval
		s.elapsed_ticks = 0;
		send_sample(s);
		s.elapsed_ticks = 16'hffff;
		send_sample(s);
		s.elapsed_ticks = 100;
		send_sample(s);
		s.elapsed_ticks = 101;
		send_sample(s);
		// non-unit quaternions drive matrix saturation
		s.quat_w = 32'sh7fffffff; s.quat_x = 32'sh7fffffff;
		s.quat_y = 32'sh80000000; s.quat_z = 32'sh7fffffff;
		s.elapsed_ticks = 1;
		send_sample(s);
		s.quat_w = 32'sh80000000; s.quat_x = 32'sh80000000;
		s.quat_y = 32'sh80000000; s.quat_z = 32'sh80000000;
		send_sample(s);
		s.quat_w = 0; s.quat_x = 32'sh40000000; s.quat_y = 0; s.quat_z = 0;
		send_sample(s);
		drain();

		// offset overflow at the mount stage, zero tick period
		write_reg(imudr_pkg::REG_OFFSET_X, 32'h7fffffff);
		write_reg(imudr_pkg::REG_OFFSET_Y, 32'h80000000);
		write_reg(imudr_pkg::REG_OFFSET_Z, 32'h7fffffff);
		write_reg(imudr_pkg::REG_TICK_PERIOD, 32'd0);
		for (int i = 0; i < 6; i++)
			send_sample(rand_sample());
		drain();

		// random phases, each with its own settings and idling mix
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			write_reg(imudr_pkg::REG_OFFSET_X,
				phase == 7 ? 32'h80000000 : 32'($signed($urandom_range(131072)) - 65536));
			write_reg(imudr_pkg::REG_OFFSET_Y,
				phase == 7 ? 32'h7fffffff : 32'($signed($urandom_range(131072)) - 65536));
			write_reg(imudr_pkg::REG_OFFSET_Z,
				phase == 7 ? 32'h80000000 : 32'($signed($urandom_range(131072)) - 65536));
			case (phase)
				0: write_reg(imudr_pkg::REG_TICK_PERIOD, imudr_pkg::TICK_PERIOD_RESET);
				3: write_reg(imudr_pkg::REG_TICK_PERIOD, 32'hffffffff);
				5: write_reg(imudr_pkg::REG_TICK_PERIOD, 32'd1);
				default: write_reg(imudr_pkg::REG_TICK_PERIOD, $urandom_range(42949672, 1));
			endcase
			for (int i = 0; i < 85; i++)
				send_sample(rand_sample());
			drain();
		end

		if (fail_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// watchdog: ~700 items, with a wide margin
	initial begin
		#20000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
